// ----- rtl/vtl_pkg.sv -----
// Package: shared types, constants and state codes for the vertex transform and lighting core
`default_nettype none
package vtl_pkg;

  localparam int FractionBits = 16;
  localparam int TableDepth   = 31;
  localparam int SlotMvp      = 0;
  localparam int SlotModel    = 16;
  localparam int SlotLdir     = 25;
  localparam int SlotLcol     = 28;
  localparam int AccWidth     = 72;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_VERTEX = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [4:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] ndc_x;
    logic signed [31:0] ndc_y;
    logic signed [31:0] ndc_z;
    logic signed [31:0] world_nrm_x;
    logic signed [31:0] world_nrm_y;
    logic signed [31:0] world_nrm_z;
    logic signed [31:0] shade_r;
    logic signed [31:0] shade_g;
    logic signed [31:0] shade_b;
    logic               w_zero;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLIP,
    ST_NRM,
    ST_DOT,
    ST_SHADE,
    ST_DIV_SETUP,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/vertex_transform_and_lighting_core.sv -----
// Top level: vertex transform and lighting core with sequencer, table, MAC and divider
// Sequence: a load transaction is taken in ST_IDLE and busy stays low; a vertex
// keeps busy high through 11 MAC passes of 5 steps and three divides (88 quotient
// bits at the default FRACTION_BITS plus setup, handoff, store), then one emit.
// The strobe is registered in ST_EMIT; a new transaction may start in the strobe cycle.
// Reset: synchronous rst clears the sequencer and the 31-word coefficient table.
// The result strobe is a one-cycle pulse; the receiver cannot stall.
`default_nettype none
module vertex_transform_and_lighting_core #(
  parameter int FRACTION_BITS = vtl_pkg::FractionBits
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  wire vtl_pkg::cmd_t cmd,
  output logic               busy,
  output logic               strobe,
  output vtl_pkg::res_t      result
);
  localparam int W = vtl_pkg::AccWidth;
  localparam logic signed [W-1:0] Ambient = W'(((64'd1 << FRACTION_BITS) + 64'd5) / 64'd10);

  logic signed [31:0] table_q [vtl_pkg::TableDepth];
  vtl_pkg::state_t state, state_next;
  logic [4:0] step;
  logic [1:0] grp;
  logic signed [31:0] pos [3];
  logic signed [31:0] nrm [3];
  logic signed [W-1:0] clip [4];
  logic signed [31:0] wn [3];
  logic signed [31:0] dotq;
  logic signed [31:0] shade [3];
  logic signed [31:0] ndc [3];
  logic wz;

  logic mclr, men;
  logic signed [31:0] ma, mb;
  logic signed [W-1:0] acc;
  logic div_start, div_busy, div_done;
  logic signed [31:0] dq;
  logic [4:0] aidx;
  logic signed [W-1:0] res_fl;

  function automatic logic signed [31:0] sat(input logic signed [W-1:0] v);
    if (v > W'(64'sh7fffffff)) return 32'sh7fffffff;
    if (v < -W'(64'sh80000000)) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign res_fl = acc >>> FRACTION_BITS;

  vtl_mac u_mac (
    .clk(clk), .clr(mclr), .en(men), .a(ma), .b(mb), .acc(acc)
  );

  vtl_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(clip[grp]), .den(clip[3]),
    .busy(div_busy), .done(div_done), .quot(dq)
  );

  // step 0..2 feed products, 3 and 4 drain the product register
  always_comb begin
    state_next = state;
    mclr = 1'b0;
    men  = (step >= 5'd1) && (step <= 5'd3);
    div_start = 1'b0;
    aidx = '0;
    ma = '0;
    mb = '0;
    case (state)
      vtl_pkg::ST_CLIP: begin
        aidx = 5'(vtl_pkg::SlotMvp + 4 * grp + (step < 5'd3 ? step : 5'd0));
        ma = table_q[aidx];
        mb = pos[step < 5'd3 ? step[1:0] : 2'd0];
        if (step == 5'd4) state_next = (grp == 2'd3) ? vtl_pkg::ST_NRM : state;
      end
      vtl_pkg::ST_NRM: begin
        aidx = 5'(vtl_pkg::SlotModel + 3 * grp + (step < 5'd3 ? step : 5'd0));
        ma = table_q[aidx];
        mb = nrm[step < 5'd3 ? step[1:0] : 2'd0];
        if (step == 5'd4 && grp == 2'd2) state_next = vtl_pkg::ST_DOT;
      end
      vtl_pkg::ST_DOT: begin
        aidx = 5'(vtl_pkg::SlotLdir + (step < 5'd3 ? step : 5'd0));
        ma = wn[step < 5'd3 ? step[1:0] : 2'd0];
        mb = table_q[aidx];
        if (step == 5'd4) state_next = vtl_pkg::ST_SHADE;
      end
      vtl_pkg::ST_SHADE: begin
        men = (step == 5'd1);
        aidx = 5'(vtl_pkg::SlotLcol + grp);
        ma = table_q[aidx];
        mb = dotq;
        if (step == 5'd4 && grp == 2'd2) state_next = vtl_pkg::ST_DIV_SETUP;
      end
      vtl_pkg::ST_DIV_SETUP: begin
        men = 1'b0;
        div_start = 1'b1;
        state_next = vtl_pkg::ST_DIV_RUN;
      end
      vtl_pkg::ST_DIV_RUN: begin
        men = 1'b0;
        if (div_done) state_next = vtl_pkg::ST_DIV_DONE;
      end
      vtl_pkg::ST_DIV_DONE: begin
        men = 1'b0;
        state_next = (grp == 2'd2) ? vtl_pkg::ST_EMIT : vtl_pkg::ST_DIV_SETUP;
      end
      vtl_pkg::ST_EMIT: begin
        men = 1'b0;
        state_next = vtl_pkg::ST_IDLE;
      end
      default: begin
        men = 1'b0;
        if (start && cmd.opcode == vtl_pkg::OP_VERTEX) state_next = vtl_pkg::ST_CLIP;
      end
    endcase
    mclr = (step == 5'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= vtl_pkg::ST_IDLE;
      step   <= '0;
      grp    <= '0;
      strobe <= 1'b0;
      for (int i = 0; i < vtl_pkg::TableDepth; i++) table_q[i] <= '0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      case (state)
        vtl_pkg::ST_IDLE: begin
          step <= '0;
          grp  <= '0;
          wz   <= 1'b0;
          if (start) begin
            if (cmd.opcode == vtl_pkg::OP_LOAD) begin
              if (cmd.coef_index < 5'(vtl_pkg::TableDepth))
                table_q[cmd.coef_index] <= cmd.coef_value;
            end else begin
              pos[0] <= cmd.pos_x; pos[1] <= cmd.pos_y; pos[2] <= cmd.pos_z;
              nrm[0] <= cmd.nrm_x; nrm[1] <= cmd.nrm_y; nrm[2] <= cmd.nrm_z;
            end
          end
        end
        vtl_pkg::ST_CLIP, vtl_pkg::ST_NRM, vtl_pkg::ST_DOT, vtl_pkg::ST_SHADE: begin
          if (step == 5'd4) begin
            step <= '0;
            case (state)
              vtl_pkg::ST_CLIP: begin
                clip[grp] <= res_fl + W'(table_q[{1'b0, grp, 2'b11}]);
                grp <= grp + 2'd1;
              end
              vtl_pkg::ST_NRM: begin
                wn[grp] <= sat(res_fl);
                grp <= (grp == 2'd2) ? 2'd0 : grp + 2'd1;
              end
              vtl_pkg::ST_DOT: begin
                dotq <= res_fl[W-1] ? 32'sd0 : sat(res_fl);
              end
              default: begin
                shade[grp] <= sat(res_fl + Ambient);
                grp <= (grp == 2'd2) ? 2'd0 : grp + 2'd1;
              end
            endcase
          end else begin
            step <= step + 5'd1;
          end
        end
        vtl_pkg::ST_DIV_DONE: begin
          ndc[grp] <= dq;
          if (clip[3] == '0) wz <= 1'b1;
          grp <= (grp == 2'd2) ? 2'd0 : grp + 2'd1;
        end
        vtl_pkg::ST_EMIT: begin
          strobe <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign busy = (state != vtl_pkg::ST_IDLE);

  always_comb begin
    result.ndc_x = ndc[0];
    result.ndc_y = ndc[1];
    result.ndc_z = ndc[2];
    result.world_nrm_x = wn[0];
    result.world_nrm_y = wn[1];
    result.world_nrm_z = wn[2];
    result.shade_r = shade[0];
    result.shade_g = shade[1];
    result.shade_b = shade[2];
    result.w_zero = wz;
  end

`ifndef SYNTHESIS
  a_strobe_after_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == vtl_pkg::ST_EMIT) else $error("strobe out of sequence");
  a_busy_no_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("strobe held");
  a_div_only_in_run: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == vtl_pkg::ST_DIV_RUN) else $error("divider done out of place");
  a_div_busy_in_run: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == vtl_pkg::ST_DIV_RUN) else $error("divider running out of place");
`endif
endmodule
`default_nettype wire

// ----- rtl/vtl_div.sv -----
// Module: bit-serial fixed-point divider with truncation and saturation
`default_nettype none
module vtl_div #(
  parameter int FRACTION_BITS = vtl_pkg::FractionBits
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  start,
  input  wire logic signed [vtl_pkg::AccWidth-1:0] num,
  input  wire logic signed [vtl_pkg::AccWidth-1:0] den,
  output logic                                 busy,
  output logic                                 done,
  output logic signed [31:0]                   quot
);
  localparam int W  = vtl_pkg::AccWidth;
  localparam int NB = W + FRACTION_BITS;
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0]  n;
  logic [W:0]     rem;
  logic [W-1:0]   d;
  logic [NB-1:0]  q;
  logic [CW-1:0]  cnt;
  logic           neg;
  logic           zero_den;
  logic           num_pos;
  logic           num_zero;
  logic [W:0]     rem_sh;
  logic [W:0]     rem_sub;
  logic [NB-FRACTION_BITS-1:0] ip;
  logic [NB-1:0]  mag;

  assign rem_sh  = {rem[W-1:0], n[NB-1]};
  assign rem_sub = rem_sh - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        neg      <= num[W-1] ^ den[W-1];
        zero_den <= (den == '0);
        num_pos  <= !num[W-1] && (num != '0);
        num_zero <= (num == '0);
        n        <= {(num[W-1] ? W'(-num) : W'(num)), {FRACTION_BITS{1'b0}}};
        d        <= den[W-1] ? W'(-den) : W'(den);
        rem      <= '0;
        q        <= '0;
        cnt      <= CW'(NB);
      end else if (busy) begin
        if (!rem_sub[W]) begin
          rem <= rem_sub;
          q   <= {q[NB-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          q   <= {q[NB-2:0], 1'b0};
        end
        n   <= {n[NB-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign ip  = q[NB-1:FRACTION_BITS];
  assign mag = q;

  always_comb begin
    if (zero_den) begin
      quot = num_pos ? 32'sh7fffffff : (num_zero ? 32'sd0 : 32'sh80000000);
    end else if (ip >= (NB-FRACTION_BITS)'(64'd1 << (32 - FRACTION_BITS))) begin
      quot = neg ? 32'sh80000000 : 32'sh7fffffff;
    end else if (neg) begin
      quot = (mag > NB'(64'h80000000)) ? 32'sh80000000 : 32'(-mag);
    end else begin
      quot = (mag > NB'(64'h7fffffff)) ? 32'sh7fffffff : 32'(mag);
    end
  end

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without run");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start) else $error("start while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
`endif
endmodule
`default_nettype wire

// ----- rtl/vtl_mac.sv -----
// Module: shared multiply-accumulate unit with a registered product
`default_nettype none
module vtl_mac (
  input  wire                                   clk,
  input  wire                                   clr,
  input  wire                                   en,
  input  wire logic signed [31:0]               a,
  input  wire logic signed [31:0]               b,
  output logic signed [vtl_pkg::AccWidth-1:0]   acc
);
  localparam int W = vtl_pkg::AccWidth;
  logic signed [63:0] prod;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      acc <= '0;
    end else if (en) begin
      acc <= acc + W'(prod);
    end
  end
endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench for the vertex transform and lighting core: directed and random transactions
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int Fb = vtl_pkg::FractionBits;
  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;
  localparam int WatchdogLimit = 20000;
  localparam int SlotUnused = 31;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  vtl_pkg::cmd_t cmd = '0;
  logic busy, strobe;
  vtl_pkg::res_t result;

  int fail_count = 0;
  int vertex_count = 0;
  int load_count = 0;
  int result_count = 0;
  int idle_cycles = 0;
  logic [31:0] coef_shadow [vtl_pkg::TableDepth];
  vtl_pkg::res_t shaded_vertices [$];

  vertex_transform_and_lighting_core dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .strobe(strobe), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint floor_q(longint v);
    return v >>> Fb;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > QMax) return QMax;
    if (v < QMin) return QMin;
    return v;
  endfunction

  // exact three-term dot product on 32-bit operands, floored to fixed point, plus a bias
  function automatic longint dot3(longint a0, longint a1, longint a2,
                                  longint b0, longint b1, longint b2, longint bias);
    logic signed [127:0] acc;
    acc = 128'(a0) * 128'(b0) + 128'(a1) * 128'(b1) + 128'(a2) * 128'(b2);
    acc = acc >>> Fb;
    return longint'(acc) + bias;
  endfunction

  function automatic longint ndc_quotient(longint num, longint den);
    logic neg;
    logic [127:0] n, d, q;
    if (den == 0) begin
      if (num > 0) return QMax;
      if (num < 0) return QMin;
      return 0;
    end
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? 128'(-num) : 128'(num);
    d = (den < 0) ? 128'(-den) : 128'(den);
    if (n / d >= (128'd1 << (32 - Fb))) return neg ? QMin : QMax;
    q = (n << Fb) / d;
    if (neg) return (q > 128'h8000_0000) ? QMin : -longint'(q);
    return (q > 128'h7FFF_FFFF) ? QMax : longint'(q);
  endfunction

  function automatic longint cw(int i);
    return longint'(signed'(coef_shadow[i]));
  endfunction

  function automatic vtl_pkg::res_t shade_vertex(vtl_pkg::cmd_t c);
    vtl_pkg::res_t r;
    longint clip [4];
    longint wn [3];
    longint nq [3];
    longint dp, ambient;
    ambient = ((64'sd1 << Fb) + 5) / 10;
    for (int i = 0; i < 4; i++)
      clip[i] = dot3(cw(vtl_pkg::SlotMvp + 4*i), cw(vtl_pkg::SlotMvp + 4*i + 1),
                     cw(vtl_pkg::SlotMvp + 4*i + 2), c.pos_x, c.pos_y, c.pos_z,
                     cw(vtl_pkg::SlotMvp + 4*i + 3));
    for (int i = 0; i < 3; i++) nq[i] = ndc_quotient(clip[i], clip[3]);
    for (int i = 0; i < 3; i++)
      wn[i] = clamp32(dot3(cw(vtl_pkg::SlotModel + 3*i), cw(vtl_pkg::SlotModel + 3*i + 1),
                           cw(vtl_pkg::SlotModel + 3*i + 2), c.nrm_x, c.nrm_y, c.nrm_z, 0));
    dp = clamp32(dot3(wn[0], wn[1], wn[2], cw(vtl_pkg::SlotLdir), cw(vtl_pkg::SlotLdir + 1),
                      cw(vtl_pkg::SlotLdir + 2), 0));
    if (dp < 0) dp = 0;
    r.ndc_x = nq[0][31:0];
    r.ndc_y = nq[1][31:0];
    r.ndc_z = nq[2][31:0];
    r.world_nrm_x = wn[0][31:0];
    r.world_nrm_y = wn[1][31:0];
    r.world_nrm_z = wn[2][31:0];
    r.shade_r = 32'(clamp32(floor_q(cw(vtl_pkg::SlotLcol) * dp) + ambient));
    r.shade_g = 32'(clamp32(floor_q(cw(vtl_pkg::SlotLcol + 1) * dp) + ambient));
    r.shade_b = 32'(clamp32(floor_q(cw(vtl_pkg::SlotLcol + 2) * dp) + ambient));
    r.w_zero = (clip[3] == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      vtl_pkg::res_t want;
      if (shaded_vertices.size() == 0) begin
        report_mismatch("unexpected result", result.ndc_x, 32'h0);
      end else begin
        want = shaded_vertices.pop_front();
        result_count++;
        if (result.ndc_x !== want.ndc_x) report_mismatch("ndc_x", result.ndc_x, want.ndc_x);
        if (result.ndc_y !== want.ndc_y) report_mismatch("ndc_y", result.ndc_y, want.ndc_y);
        if (result.ndc_z !== want.ndc_z) report_mismatch("ndc_z", result.ndc_z, want.ndc_z);
        if (result.world_nrm_x !== want.world_nrm_x)
          report_mismatch("world_nrm_x", result.world_nrm_x, want.world_nrm_x);
        if (result.world_nrm_y !== want.world_nrm_y)
          report_mismatch("world_nrm_y", result.world_nrm_y, want.world_nrm_y);
        if (result.world_nrm_z !== want.world_nrm_z)
          report_mismatch("world_nrm_z", result.world_nrm_z, want.world_nrm_z);
        if (result.shade_r !== want.shade_r) report_mismatch("shade_r", result.shade_r, want.shade_r);
        if (result.shade_g !== want.shade_g) report_mismatch("shade_g", result.shade_g, want.shade_g);
        if (result.shade_b !== want.shade_b) report_mismatch("shade_b", result.shade_b, want.shade_b);
        if (result.w_zero !== want.w_zero)
          report_mismatch("w_zero", 32'(result.w_zero), 32'(want.w_zero));
      end
    end
  end

  // watchdog: cycles with no transaction in either direction
  always @(posedge clk) begin
    if ((start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("watchdog expired at %0t", $realtime);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_cmd(vtl_pkg::cmd_t c);
    @(negedge clk);
    cmd <= c;
    start <= 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    if (c.opcode == vtl_pkg::OP_LOAD) begin
      if (c.coef_index < vtl_pkg::TableDepth) coef_shadow[c.coef_index] = c.coef_value;
      load_count++;
    end else begin
      shaded_vertices.push_back(shade_vertex(c));
      vertex_count++;
    end
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic load_coef(int idx, logic [31:0] v);
    vtl_pkg::cmd_t c;
    c = '0;
    c.opcode = vtl_pkg::OP_LOAD;
    c.coef_index = 5'(idx);
    c.coef_value = v;
    c.pos_x = $urandom;
    c.nrm_z = $urandom;
    send_cmd(c);
  endtask

  task automatic send_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] nx, logic [31:0] ny, logic [31:0] nz);
    vtl_pkg::cmd_t c;
    c.opcode = vtl_pkg::OP_VERTEX;
    c.coef_index = 5'($urandom);
    c.coef_value = $urandom;
    c.pos_x = px; c.pos_y = py; c.pos_z = pz;
    c.nrm_x = nx; c.nrm_y = ny; c.nrm_z = nz;
    send_cmd(c);
  endtask

  task automatic drain();
    while (shaded_vertices.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 8 << Fb)) - (4 << Fb));
      3: return 32'(signed'($urandom_range(0, 1 << Fb)) - (1 << (Fb - 1)));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] fx(int whole);
    return 32'(whole <<< Fb);
  endfunction

  task automatic load_identity_scene();
    for (int i = 0; i < vtl_pkg::TableDepth; i++) load_coef(i, 32'h0);
    for (int i = 0; i < 4; i++) load_coef(vtl_pkg::SlotMvp + 5*i, fx(1));
    for (int i = 0; i < 3; i++) load_coef(vtl_pkg::SlotModel + 4*i, fx(1));
    load_coef(vtl_pkg::SlotLdir + 2, fx(1));
    for (int i = 0; i < 3; i++) load_coef(vtl_pkg::SlotLcol + i, fx(1));
  endtask

  task automatic test_reset_table();
    send_vertex(fx(1), fx(2), fx(3), fx(1), 0, 0);
    send_vertex(0, 0, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_directed_vertices();
    load_identity_scene();
    send_vertex(fx(2), fx(-3), fx(1), 0, 0, fx(1));
    send_vertex(fx(1), fx(1), fx(1), 0, 0, fx(-1));
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    load_coef(SlotUnused, fx(7));
    load_coef(vtl_pkg::SlotMvp + 15, 32'h0000_0001);
    send_vertex(fx(5), fx(-5), 0, 0, 0, fx(2));
    load_coef(vtl_pkg::SlotMvp + 15, 32'h0);
    send_vertex(fx(1), fx(-1), 0, 0, 0, 0);
    load_coef(vtl_pkg::SlotLcol, 32'h7FFF_FFFF);
    load_coef(vtl_pkg::SlotLcol + 1, 32'h8000_0000);
    send_vertex(0, 0, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF);
    drain();
  endtask

  task automatic test_random_scenes();
    int sent;
    int burst;
    sent = 0;
    while (sent < 600) begin
      if ($urandom_range(0, 9) == 0) begin
        drain();
        for (int i = 0; i < vtl_pkg::TableDepth; i++) load_coef(i, rand_word());
        sent += vtl_pkg::TableDepth;
      end
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst; b++) begin
        if ($urandom_range(0, 4) == 0)
          load_coef($urandom_range(0, 31), rand_word());
        else
          send_vertex(rand_word(), rand_word(), rand_word(),
                      rand_word(), rand_word(), rand_word());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 40)) @(negedge clk);
    end
    drain();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < vtl_pkg::TableDepth; i++) coef_shadow[i] = 32'h0;
    test_reset_table();
    test_directed_vertices();
    test_random_scenes();
    repeat (400) @(negedge clk);
    $display("covered %0d vertex and %0d load transactions, %0d results checked",
             vertex_count, load_count, result_count);
    if (fail_count == 0 && shaded_vertices.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
